>>> sv/circle_point_collision_response_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the collision response unit
// Shared property shapes used by the top-level checks.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_POINT_COLLISION_RESPONSE_UNIT_MACROS_SVH
`define CIRCLE_POINT_COLLISION_RESPONSE_UNIT_MACROS_SVH

// implication checked on every clock outside reset
`define CPC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define CPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/cpc_pkg.sv
// ----------------------------------------------------------------------------
// Collision response package
// Shared types and constants for the collision response unit.
// ----------------------------------------------------------------------------
`default_nettype none
package cpc_pkg;
   localparam int MaxPoints = 256;
   localparam int IdxW      = 8;
   localparam int CntW      = 9;
   localparam int QueueDepth = 2;

   localparam logic [0:0] CSR_ROBOT_RADIUS = 1'd0;
   localparam logic [0:0] CSR_TOUCH_MODE   = 1'd1;

   typedef struct packed {
      logic signed [31:0] robot_x;
      logic signed [31:0] robot_y;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic [23:0]        point_radius;
      logic [7:0]         point_index;
      logic               last;
      logic               active_control;
   } req_type;

   typedef struct packed {
      logic [8:0]         hit_count;
      logic [8:0]         new_touches;
      logic signed [31:0] push_x;
      logic signed [31:0] push_y;
      logic signed [31:0] new_robot_x;
      logic signed [31:0] new_robot_y;
      logic [31:0]        collision_total;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic signed [31:0] robot_x;
      logic signed [31:0] robot_y;
      logic signed [26:0] dx;
      logic signed [26:0] dy;
      logic               near;
      logic [24:0]        reach;
      logic [7:0]         point_index;
      logic               last;
      logic               active_control;
   } task_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQRT, ST_MUL, ST_DIV, ST_ACC, ST_OUT
   } back_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sd2147483647) return 32'sh7fffffff;
      if (v < -34'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction
endpackage
`default_nettype wire

>>> sv/cpc_front.sv
// ----------------------------------------------------------------------------
// Collision front end
// Takes request transfers, forms differences, range check and reach.
// ----------------------------------------------------------------------------
`default_nettype none
module cpc_front import cpc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   input  wire logic [23:0] robot_radius,
   output logic             task_valid,
   input  wire logic        task_ready,
   output task_type         task_data
);
   logic [$clog2(QueueDepth+1)-1:0] cnt_ff, cnt_in;
   logic [$clog2(QueueDepth)-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   task_type q_ff [QueueDepth];
   task_type t;
   logic signed [32:0] dx, dy;
   logic push, pop;

   always_comb begin
      dx = 33'(req_data.point_x) - 33'(req_data.robot_x);
      dy = 33'(req_data.point_y) - 33'(req_data.robot_y);
      t.robot_x = req_data.robot_x;
      t.robot_y = req_data.robot_y;
      t.dx = dx[26:0];
      t.dy = dy[26:0];
      t.near = (dx < 33'sd33554432) && (dx > -33'sd33554432) &&
               (dy < 33'sd33554432) && (dy > -33'sd33554432);
      t.reach = 25'(robot_radius) + 25'(req_data.point_radius);
      t.point_index = req_data.point_index;
      t.last = req_data.last;
      t.active_control = req_data.active_control;
   end

   assign req_ready  = (cnt_ff != ($bits(cnt_ff))'(QueueDepth));
   assign task_valid = (cnt_ff != '0);
   assign task_data  = q_ff[rp_ff];
   assign push = req_valid && req_ready;
   assign pop  = task_valid && task_ready;

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= '0;
         rp_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
      if (push) q_ff[wp_ff] <= t;
   end
endmodule
`default_nettype wire

>>> sv/cpc_back.sv
// ----------------------------------------------------------------------------
// Collision back end
// Iterative square root, push term division, accumulation and result.
// ----------------------------------------------------------------------------
`default_nettype none
module cpc_back import cpc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     task_valid,
   output logic          task_ready,
   input  wire task_type task_data,
   input  wire logic     touch_mode,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);
   back_state_type st_ff, st_in;
   task_type tk_ff;
   logic [51:0] rem_ff, rem_in;
   logic [26:0] root_ff, root_in;
   logic [4:0]  step_ff, step_in;
   logic [25:0] d_ff;
   logic        hit_ff;
   logic signed [26:0] depth_ff;
   logic [52:0] qx_ff, qy_ff, rx_ff, ry_ff;
   logic [5:0]  dstep_ff;
   logic        negx_ff, negy_ff;
   logic signed [31:0] accx_ff, accy_ff;
   logic [CntW-1:0] hits_ff, newt_ff;
   logic [31:0] total_ff;
   logic [MaxPoints-1:0] touched_ff;
   rsp_type out_ff;
   logic out_v_ff;
   logic out_free;
   logic [53:0] r2, cand;
   logic [53:0] shx, shy;
   logic [52:0] ax, ay;
   logic [26:0] abs_tdx, abs_tdy, abs_kdx, abs_kdy, abs_depth;
   logic [51:0] sqx, sqy, sq_sum;
   logic signed [33:0] sx, sy;
   logic [32:0] tsum;
   logic [8:0]  hits_nx, newt_nx;
   logic        newt;

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign out_free  = !out_v_ff || rsp_ready;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (task_valid) st_in = ST_SQRT;
         ST_SQRT: if (step_ff == 5'd25) st_in = ST_MUL;
         ST_MUL:  st_in = ST_DIV;
         ST_DIV:  if (dstep_ff == 6'd53) st_in = ST_ACC;
         ST_ACC:  st_in = ST_OUT;
         ST_OUT:  if (!tk_ff.last || out_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   assign task_ready = (st_ff == ST_IDLE);

   always_comb begin
      abs_tdx = (task_data.dx < 0) ? -task_data.dx : task_data.dx;
      abs_tdy = (task_data.dy < 0) ? -task_data.dy : task_data.dy;
      sqx = abs_tdx[25:0] * abs_tdx[25:0];
      sqy = abs_tdy[25:0] * abs_tdy[25:0];
      sq_sum = sqx + sqy;
      // one root bit per cycle (restoring)
      r2 = 54'(rem_ff);
      cand = 54'({root_ff, 2'b01}) << (2 * (25 - step_ff));
      rem_in = rem_ff;
      if (r2 >= cand) begin
         rem_in = 52'(r2 - cand);
         root_in = (root_ff << 1) | 27'd1;
      end else begin
         root_in = root_ff << 1;
      end
      step_in = step_ff + 1'b1;
   end

   always_comb begin
      abs_kdx = (tk_ff.dx < 0) ? -tk_ff.dx : tk_ff.dx;
      abs_kdy = (tk_ff.dy < 0) ? -tk_ff.dy : tk_ff.dy;
      abs_depth = (depth_ff < 0) ? -depth_ff : depth_ff;
      ax = abs_depth * abs_kdx[25:0];
      ay = abs_depth * abs_kdy[25:0];
      shx = {rx_ff, qx_ff[52]};
      shy = {ry_ff, qy_ff[52]};
      sx = 34'(accx_ff) + (negx_ff ? -34'(signed'({1'b0, qx_ff[31:0]}))
                                   : 34'(signed'({1'b0, qx_ff[31:0]})));
      sy = 34'(accy_ff) + (negy_ff ? -34'(signed'({1'b0, qy_ff[31:0]}))
                                   : 34'(signed'({1'b0, qy_ff[31:0]})));
      newt = !touched_ff[tk_ff.point_index];
      hits_nx = (hits_ff == 9'd511) ? hits_ff : hits_ff + 1'b1;
      newt_nx = (newt_ff == 9'd511) ? newt_ff : newt_ff + 1'b1;
      tsum = 33'(total_ff) + 33'(newt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         accx_ff <= '0;
         accy_ff <= '0;
         hits_ff <= '0;
         newt_ff <= '0;
         total_ff <= '0;
         touched_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_OUT && tk_ff.last && out_free) out_v_ff <= 1'b1;
         else if (rsp_ready) out_v_ff <= 1'b0;
         unique case (st_ff)
            ST_IDLE: if (task_valid) begin
               tk_ff <= task_data;
               rem_ff <= sq_sum;
               root_ff <= '0;
               step_ff <= '0;
            end
            ST_SQRT: begin
               rem_ff <= rem_in;
               root_ff <= root_in;
               step_ff <= step_in;
            end
            ST_MUL: begin
               d_ff <= root_ff[25:0];
               hit_ff <= tk_ff.near && (27'(root_ff) < 27'(tk_ff.reach));
               depth_ff <= 27'(root_ff) - 27'(tk_ff.reach);
               dstep_ff <= '0;
            end
            ST_DIV: begin
               if (dstep_ff == 6'd0) begin
                  qx_ff <= ax;
                  qy_ff <= ay;
                  rx_ff <= '0;
                  ry_ff <= '0;
                  negx_ff <= (depth_ff < 0) != (tk_ff.dx < 0);
                  negy_ff <= (depth_ff < 0) != (tk_ff.dy < 0);
               end else begin
                  rx_ff <= (shx >= 54'(d_ff)) ? 53'(shx - 54'(d_ff)) : shx[52:0];
                  ry_ff <= (shy >= 54'(d_ff)) ? 53'(shy - 54'(d_ff)) : shy[52:0];
                  qx_ff <= {qx_ff[51:0], shx >= 54'(d_ff)};
                  qy_ff <= {qy_ff[51:0], shy >= 54'(d_ff)};
               end
               dstep_ff <= dstep_ff + 1'b1;
            end
            ST_ACC: begin
               if (hit_ff) begin
                  if (d_ff == '0) begin
                     accx_ff <= sat32(34'(accx_ff) + 34'(depth_ff));
                  end else begin
                     accx_ff <= sat32(sx);
                     accy_ff <= sat32(sy);
                  end
                  hits_ff <= hits_nx;
                  if (newt) begin
                     newt_ff <= newt_nx;
                     touched_ff[tk_ff.point_index] <= 1'b1;
                  end
               end else if (!touch_mode) begin
                  touched_ff[tk_ff.point_index] <= 1'b0;
               end
            end
            ST_OUT: if (tk_ff.last && out_free) begin
               out_ff.hit_count <= hits_ff;
               out_ff.new_touches <= newt_ff;
               out_ff.push_x <= accx_ff;
               out_ff.push_y <= accy_ff;
               out_ff.new_robot_x <= tk_ff.robot_x;
               out_ff.new_robot_y <= tk_ff.robot_y;
               out_ff.collision_total <= total_ff;
               if (hits_ff != '0) begin
                  if (touch_mode || tk_ff.active_control) begin
                     total_ff <= tsum[32] ? 32'hffffffff : tsum[31:0];
                     out_ff.collision_total <= tsum[32] ? 32'hffffffff : tsum[31:0];
                  end
                  if (tk_ff.active_control) begin
                     out_ff.new_robot_x <= sat32(34'(tk_ff.robot_x) + 34'(accx_ff));
                     out_ff.new_robot_y <= sat32(34'(tk_ff.robot_y) + 34'(accy_ff));
                  end
               end
               accx_ff <= '0;
               accy_ff <= '0;
               hits_ff <= '0;
               newt_ff <= '0;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> sv/circle_point_collision_response_unit.sv
// ----------------------------------------------------------------------------
// Circle-point collision response unit
// Penetration push, hit counts and corrected position per pass of points.
// ----------------------------------------------------------------------------
// channel  dir  payload
// req      in   req_type, one obstacle point
// rsp      out  rsp_type, one per pass on the last point
// csr      in   index/data write, no read-back
// In the back each point runs load, 26-step square root, depth step,
// 54-step divider, accumulate and result steps.
// A two-entry queue lets the front take points while the back works.
// A waiting result holds the back only at the last point of the next pass.
// Synchronous reset clears counters, accumulators and touched flags.
`default_nettype none
`include "circle_point_collision_response_unit_macros.svh"
module circle_point_collision_response_unit import cpc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_write,
   input  wire logic [0:0]  csr_index,
   input  wire logic [23:0] csr_data
);
   logic [23:0] radius_ff;
   logic        mode_ff;
   logic        task_valid, task_ready;
   task_type    task_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 24'd262144;
         mode_ff   <= 1'b0;
      end else if (csr_write) begin
         if (csr_index == CSR_ROBOT_RADIUS) radius_ff <= csr_data;
         if (csr_index == CSR_TOUCH_MODE) mode_ff <= csr_data[0];
      end
   end

   cpc_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .robot_radius(radius_ff), .task_valid, .task_ready, .task_data
   );

   cpc_back u_back (
      .clock, .reset, .task_valid, .task_ready, .task_data,
      .touch_mode(mode_ff), .rsp_valid, .rsp_ready, .rsp_data
   );

   `CPC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data),
      "result changed before transfer")
   `CPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
      "result dropped before transfer")
endmodule
`default_nettype wire
